// ===== sv/entropy_source_mixer_unit_macros.svh =====
// Assertion macros shared by the entropy source mixer RTL.
`ifndef ENTROPY_SOURCE_MIXER_UNIT_MACROS_SVH
`define ENTROPY_SOURCE_MIXER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ESM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("entropy source mixer: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define ESM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("entropy source mixer: next-cycle check failed");

`endif

// ===== sv/esm_pkg.sv =====
// Package for the entropy source mixer: constants, control word and microprogram.
`timescale 1ns / 1ps
package esm_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned RND_W  = 4;
    localparam int unsigned PC_W   = 6;

    localparam logic [DATA_W-1:0] GOLDEN_K = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [DATA_W-1:0] STACK_K  = 64'h517C_C1B7_2722_0A95;
    localparam logic [DATA_W-1:0] POOL_K   = 64'h85EB_CA6B_3B4F_4A5F;
    localparam logic [DATA_W-1:0] CYCLE_K  = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [DATA_W-1:0] FMIX_K1  = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [DATA_W-1:0] FMIX_K2  = 64'hC4CE_B9FE_1A85_EC53;
    localparam int unsigned ROT_SYS    = 23;
    localparam int unsigned ROT_TICK   = 37;
    localparam int unsigned SHR_INT    = 13;
    localparam int unsigned FMIX_SHIFT = 33;

    localparam logic [RND_W-1:0] MIX_ROUNDS_RST = 4'd7;
    localparam logic [RND_W-1:0] ACC_ROUNDS_RST = 4'd3;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_MIX_ROUNDS = 1'b0,
        REG_ACC_ROUNDS = 1'b1
    } t_reg;

    // Which 32-bit halves go through the shared multiplier
    typedef enum logic [1:0] {
        MP_NONE,
        MP_LL,
        MP_LH,
        MP_HL
    } t_mpart;

    typedef enum logic [1:0] {
        SRC_X,
        SRC_STACK,
        SRC_POOL,
        SRC_CYC
    } t_src;

    typedef enum logic [2:0] {
        K_STACK,
        K_POOL,
        K_CYC,
        K_F1,
        K_F2
    } t_kc;

    typedef enum logic [1:0] {
        SOP_NONE,
        SOP_LOAD,
        SOP_ADD
    } t_sop;

    typedef enum logic [2:0] {
        XOP_NONE,
        XOP_XOR_SUM,
        XOP_FOLD_SUM,
        XOP_FOLDG_SUM,
        XOP_FOLD,
        XOP_START_ACC,
        XOP_FINISH
    } t_xop;

    typedef enum logic [1:0] {
        CNT_NONE,
        CNT_INC,
        CNT_CLR
    } t_cnt;

    typedef enum logic [1:0] {
        J_NEXT,
        J_IFDONE,
        J_ALWAYS,
        J_END
    } t_jmp;

    typedef enum logic [0:0] {
        B_MIX,
        B_ACC
    } t_bsel;

    typedef struct packed {
        t_mpart          mul_part;
        t_src            src;
        t_kc             kc;
        t_sop            sum_op;
        t_xop            x_op;
        t_cnt            cnt_op;
        t_jmp            jump;
        t_bsel           bsel;
        logic [PC_W-1:0] target;
    } t_ucw;

    // Program layout
    localparam logic [PC_W-1:0] ST_MIX_CHK  = 6'd12;
    localparam logic [PC_W-1:0] ST_MIX_BODY = 6'd13;
    localparam logic [PC_W-1:0] ST_MIX_END  = 6'd22;
    localparam logic [PC_W-1:0] ST_ACC_CHK  = 6'd23;
    localparam logic [PC_W-1:0] ST_ACC_BODY = 6'd24;
    localparam logic [PC_W-1:0] ST_DONE     = 6'd33;

    localparam t_ucw UCW_NOP = '{MP_NONE, SRC_X, K_F1, SOP_NONE, XOP_NONE,
                                 CNT_NONE, J_NEXT, B_MIX, '0};

    // One 64x64 low-half multiply in four steps; the last step leaves x_op to the caller
    function automatic t_ucw mul_step(input logic [1:0] ph, input t_src src, input t_kc kc);
        t_ucw w;
        w     = UCW_NOP;
        w.src = src;
        w.kc  = kc;
        case (ph)
            2'd0:    w.mul_part = MP_LL;
            2'd1: begin
                w.mul_part = MP_LH;
                w.sum_op   = SOP_LOAD;
            end
            2'd2: begin
                w.mul_part = MP_HL;
                w.sum_op   = SOP_ADD;
            end
            default: w.mul_part = MP_NONE;
        endcase
        return w;
    endfunction

    // One fmix64-style round, nine steps, jumping back to its check step
    function automatic t_ucw round_step(input logic [3:0] o, input logic [PC_W-1:0] back);
        t_ucw w;
        w = UCW_NOP;
        case (o) inside
            4'd0:        w.x_op = XOP_FOLD;
            [4'd1:4'd4]: begin
                w = mul_step(2'(o - 4'd1), SRC_X, K_F1);
                if (o == 4'd4) w.x_op = XOP_FOLD_SUM;
            end
            [4'd5:4'd8]: begin
                w = mul_step(2'(o - 4'd5), SRC_X, K_F2);
                if (o == 4'd8) begin
                    w.x_op   = XOP_FOLDG_SUM;
                    w.cnt_op = CNT_INC;
                    w.jump   = J_ALWAYS;
                    w.target = back;
                end
            end
            default:     w = UCW_NOP;
        endcase
        return w;
    endfunction

    // Microprogram read-only table
    function automatic t_ucw ucode(input logic [PC_W-1:0] pc);
        t_ucw w;
        w = UCW_NOP;
        if (pc < ST_MIX_CHK) begin
            case (pc[3:2])
                2'd0:    w = mul_step(pc[1:0], SRC_STACK, K_STACK);
                2'd1:    w = mul_step(pc[1:0], SRC_POOL, K_POOL);
                default: w = mul_step(pc[1:0], SRC_CYC, K_CYC);
            endcase
            if (pc[1:0] == 2'd3) w.x_op = XOP_XOR_SUM;
        end else if (pc == ST_MIX_CHK) begin
            w.jump   = J_IFDONE;
            w.bsel   = B_MIX;
            w.target = ST_MIX_END;
        end else if (pc inside {[ST_MIX_BODY:ST_MIX_END-6'd1]}) begin
            w = round_step(4'(pc - ST_MIX_BODY), ST_MIX_CHK);
        end else if (pc == ST_MIX_END) begin
            w.x_op   = XOP_START_ACC;
            w.cnt_op = CNT_CLR;
        end else if (pc == ST_ACC_CHK) begin
            w.jump   = J_IFDONE;
            w.bsel   = B_ACC;
            w.target = ST_DONE;
        end else if (pc inside {[ST_ACC_BODY:ST_DONE-6'd1]}) begin
            w = round_step(4'(pc - ST_ACC_BODY), ST_ACC_CHK);
        end else begin
            w.x_op = XOP_FINISH;
            w.jump = J_END;
        end
        return w;
    endfunction

endpackage

// ===== sv/entropy_source_mixer_unit.sv =====
// Entropy source mixer: microcoded fold and fmix64-style rehash of entropy samples.
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ----------------------------------------
//  request   in         i_valid / o_stall      i_no_sample, seven sample fields
//  result    out        o_valid / i_stall      o_mixed_value
//  config    in         i_cfg_wr_en            i_cfg_idx, i_cfg_wdata
//
//  Order: a sample request runs three sample multiplies, the mix rounds and then the
//  accumulator rounds, a no-sample one only the accumulator rounds; the next request
//  waits for the result; a 64-bit multiply is four steps of the shared 32x32 unit.
//  Reset (synchronous, active low) idles the sequencer, drops the result, loads 7/3 rounds.
//  A request is taken only while the sequencer is idle; the result register frees the
//  sequencer, which waits at its final step only if an earlier result is still stalled.
`timescale 1ns / 1ps
`include "entropy_source_mixer_unit_macros.svh"

module entropy_source_mixer_unit
    import esm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_no_sample,
    input  logic [DATA_W-1:0] i_perf_counter,
    input  logic [DATA_W-1:0] i_system_time,
    input  logic [DATA_W-1:0] i_tick_count,
    input  logic [DATA_W-1:0] i_interrupt_time,
    input  logic [DATA_W-1:0] i_stack_address,
    input  logic [DATA_W-1:0] i_pool_address,
    input  logic [HALF_W-1:0] i_cycle_count,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_mixed_value,
    // configuration
    input  logic              i_cfg_wr_en,
    input  logic [0:0]        i_cfg_idx,
    input  logic [RND_W-1:0]  i_cfg_wdata
);

    // Control state
    logic              r_busy, n_busy;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [RND_W-1:0]  r_cnt, n_cnt;
    logic              r_ns, n_ns;
    logic              r_out_vld, n_out_vld;
    logic [RND_W-1:0]  r_mix_rounds, r_acc_rounds;
    logic [DATA_W-1:0] r_acc, n_acc;

    // Datapath
    logic [DATA_W-1:0] r_x, n_x;
    logic [DATA_W-1:0] r_w, n_w;
    logic [DATA_W-1:0] r_p, n_p;
    logic [DATA_W-1:0] r_sum, n_sum;
    logic [DATA_W-1:0] r_gold, n_gold;
    logic [DATA_W-1:0] r_stk, n_stk;
    logic [DATA_W-1:0] r_pool, n_pool;
    logic [HALF_W-1:0] r_cyc, n_cyc;
    logic [DATA_W-1:0] r_out, n_out;

    t_ucw              uc;
    logic              accept;
    logic              advance;
    logic              loop_done;
    logic [RND_W-1:0]  bound;
    logic [DATA_W-1:0] src_val;
    logic [DATA_W-1:0] k_val;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [DATA_W-1:0] mul_res;
    logic [DATA_W-1:0] sum_s;
    logic [DATA_W-1:0] fold_s;
    logic [DATA_W-1:0] premix;

    assign uc      = ucode(r_pc);
    assign o_stall = r_busy;
    assign accept  = i_valid && !r_busy;
    // hold the final step while an older result is still waiting downstream
    assign advance = r_busy && !(uc.x_op == XOP_FINISH && r_out_vld && i_stall);

    assign o_valid       = r_out_vld;
    assign o_mixed_value = r_out;

    // rotations and the shift of the fold, taken straight from the request
    assign premix = i_perf_counter
                  ^ ((i_system_time << ROT_SYS) | (i_system_time >> (DATA_W - ROT_SYS)))
                  ^ ((i_tick_count << ROT_TICK) | (i_tick_count >> (DATA_W - ROT_TICK)))
                  ^ (i_interrupt_time >> SHR_INT);

    // Operand selection for the shared multiplier
    always_comb begin
        case (uc.src)
            SRC_X:     src_val = r_x;
            SRC_STACK: src_val = r_stk;
            SRC_POOL:  src_val = r_pool;
            SRC_CYC:   src_val = {{HALF_W{1'b0}}, r_cyc};
            default:   src_val = r_x;
        endcase
        case (uc.kc)
            K_STACK: k_val = STACK_K;
            K_POOL:  k_val = POOL_K;
            K_CYC:   k_val = CYCLE_K;
            K_F1:    k_val = FMIX_K1;
            K_F2:    k_val = FMIX_K2;
            default: k_val = FMIX_K1;
        endcase
        case (uc.mul_part)
            MP_LH: begin
                mul_a = src_val[HALF_W-1:0];
                mul_b = k_val[DATA_W-1:HALF_W];
            end
            MP_HL: begin
                mul_a = src_val[DATA_W-1:HALF_W];
                mul_b = k_val[HALF_W-1:0];
            end
            default: begin
                mul_a = src_val[HALF_W-1:0];
                mul_b = k_val[HALF_W-1:0];
            end
        endcase
    end

    assign mul_res = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

    // only the low half of a cross product reaches the low 64 bits of the result
    assign sum_s  = r_sum + {r_p[HALF_W-1:0], {HALF_W{1'b0}}};
    assign fold_s = sum_s ^ (sum_s >> FMIX_SHIFT);

    assign bound     = (uc.bsel == B_MIX) ? r_mix_rounds : r_acc_rounds;
    assign loop_done = (r_cnt == bound);

    // Next-value logic of sequencer and datapath
    always_comb begin
        n_busy    = r_busy;
        n_pc      = r_pc;
        n_cnt     = r_cnt;
        n_ns      = r_ns;
        n_out_vld = r_out_vld;
        n_acc     = r_acc;
        n_x       = r_x;
        n_w       = r_w;
        n_p       = r_p;
        n_sum     = r_sum;
        n_gold    = r_gold;
        n_stk     = r_stk;
        n_pool    = r_pool;
        n_cyc     = r_cyc;
        n_out     = r_out;

        // drop the result once it is taken
        if (r_out_vld && !i_stall) n_out_vld = 1'b0;

        if (accept) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_gold = '0;
            n_stk  = i_stack_address;
            n_pool = i_pool_address;
            n_cyc  = i_cycle_count;
            n_ns   = i_no_sample;
            if (i_no_sample) begin
                // skip straight to the accumulator rounds
                n_x  = r_acc;
                n_pc = ST_ACC_CHK;
            end else begin
                n_x  = premix;
                n_pc = '0;
            end
        end else if (advance) begin
            if (uc.mul_part != MP_NONE) n_p = mul_res;

            case (uc.sum_op)
                SOP_LOAD: n_sum = r_p;
                SOP_ADD:  n_sum = sum_s;
                default:  n_sum = r_sum;
            endcase

            case (uc.x_op)
                XOP_XOR_SUM:   n_x = r_x ^ sum_s;
                XOP_FOLD_SUM:  n_x = fold_s;
                XOP_FOLDG_SUM: n_x = fold_s ^ r_gold;
                XOP_FOLD:      n_x = r_x ^ (r_x >> FMIX_SHIFT);
                XOP_START_ACC: begin
                    n_w = r_x;
                    n_x = r_acc ^ r_x;
                end
                XOP_FINISH: begin
                    n_out_vld = 1'b1;
                    n_out     = r_ns ? r_x : r_w;
                    if (!r_ns) n_acc = r_x;
                end
                default:       n_x = r_x;
            endcase

            case (uc.cnt_op)
                CNT_INC: begin
                    n_cnt  = r_cnt + 4'd1;
                    n_gold = r_gold + GOLDEN_K;
                end
                CNT_CLR: begin
                    n_cnt  = '0;
                    n_gold = '0;
                end
                default: n_cnt = r_cnt;
            endcase

            case (uc.jump)
                J_IFDONE: n_pc = loop_done ? uc.target : r_pc + 6'd1;
                J_ALWAYS: n_pc = uc.target;
                J_END: begin
                    n_busy = 1'b0;
                    n_pc   = '0;
                end
                default:  n_pc = r_pc + 6'd1;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pc      <= '0;
            r_cnt     <= '0;
            r_ns      <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc     <= GOLDEN_K;
        end else begin
            r_busy    <= n_busy;
            r_pc      <= n_pc;
            r_cnt     <= n_cnt;
            r_ns      <= n_ns;
            r_out_vld <= n_out_vld;
            r_acc     <= n_acc;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_rounds <= MIX_ROUNDS_RST;
            r_acc_rounds <= ACC_ROUNDS_RST;
        end else if (i_cfg_wr_en) begin
            case (t_reg'(i_cfg_idx))
                REG_MIX_ROUNDS: r_mix_rounds <= i_cfg_wdata;
                REG_ACC_ROUNDS: r_acc_rounds <= i_cfg_wdata;
                default:        r_mix_rounds <= r_mix_rounds;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_w    <= n_w;
        r_p    <= n_p;
        r_sum  <= n_sum;
        r_gold <= n_gold;
        r_stk  <= n_stk;
        r_pool <= n_pool;
        r_cyc  <= n_cyc;
        r_out  <= n_out;
    end

    // Checks on the sequencer
    `ESM_ASSERT_IMP(a_pc_range, i_clk, i_rst_n, r_busy, r_pc <= ST_DONE)
    `ESM_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_busy && uc.jump == J_IFDONE, r_cnt <= bound)
    `ESM_ASSERT_NXT(a_finish_vld, i_clk, i_rst_n, advance && uc.x_op == XOP_FINISH, r_out_vld)
    `ESM_ASSERT_NXT(a_ns_acc_hold, i_clk, i_rst_n, accept && i_no_sample, r_acc == $past(r_acc))

endmodule
